// ===== sv/gpio_lk_pkg.sv =====
// Package for the GPIO port with configuration lock key.
// Holds register index codes, access codes, reset constants and the key step type.
// No dependencies.
package gpio_lk_pkg;

    localparam int unsigned PinMax = 16;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned IndexWidth = 3;
    localparam int unsigned KeyBit = 16;

    localparam logic [DataWidth-1:0] CfgReset = 32'h4444_4444;

    localparam logic OpRead = 1'b0;
    localparam logic OpWrite = 1'b1;

    localparam logic [IndexWidth-1:0] RegCfgLow = 3'd0;
    localparam logic [IndexWidth-1:0] RegCfgHigh = 3'd1;
    localparam logic [IndexWidth-1:0] RegInData = 3'd2;
    localparam logic [IndexWidth-1:0] RegOutData = 3'd3;
    localparam logic [IndexWidth-1:0] RegLock = 3'd4;

    // Progress through the lock key sequence.
    typedef enum logic [3:0] {
        KEY_IDLE = 4'b0001,
        KEY_SET1 = 4'b0010,
        KEY_CLR = 4'b0100,
        KEY_SET2 = 4'b1000
    } t_key_step;

    // Expands eight pin enables into a word with one 4-bit field per pin.
    function automatic logic [DataWidth-1:0] nibble_mask(input logic [7:0] pins);
        logic [DataWidth-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (pins[i]) begin
                m[4*i +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/gpio_port_with_lock_sequence_top.sv =====
// Top level of the GPIO port register block with configuration lock key.
// Depends on gpio_lk_pkg for register codes, reset values and the key step type.
// Single module; all state and the result register live here.

// This block is the register file of a 16-pin general purpose I/O port, driven by a
// stream of bus accesses. Each accepted item is one read or write of the low or
// high configuration word (one 4-bit field per pin), the input data register (the
// sampled pin levels that arrive with the item), the output data register, or the
// lock register. Every item yields exactly one result item holding the read data
// (zero for writes), the output data register and the lock status as they stand
// after the access. The lock register is armed by the key sequence: write with
// bit 16 set, write with bit 16 clear, write with bit 16 set again with the same
// lock bits, then read the lock register. That read returns bit 16 clear and
// engages the lock; from then on the lock register ignores writes and the
// configuration fields of locked pins hold their value until reset. A write that
// breaks the sequence restarts it. The block takes one item per clock cycle while
// results are taken: the register update and the result are computed in a
// single pass of logic from the accepted item and captured in the result register.
// A new item can enter in the same cycle that the previous result is taken; while
// a result waits in the result register, the input is stalled.
// PIN_COUNT (8 to 16) sets how many pins exist; pins above it read as zero and
// keep their reset configuration.
module gpio_port_with_lock_sequence_top
    import gpio_lk_pkg::*;
#(
    parameter int unsigned PIN_COUNT = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Access channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [IndexWidth-1:0] i_reg_index,
    input  logic [DataWidth-1:0]  i_write_data,
    input  logic [PinMax-1:0]     i_pin_in,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DataWidth-1:0]  o_read_data,
    output logic [PinMax-1:0]     o_pin_out,
    output logic                  o_lock_active
);

    // Mask of the pins that exist in this configuration.
    localparam logic [PinMax-1:0] PinMask = PinMax'((33'd1 << PIN_COUNT) - 33'd1);

    // Architectural state.
    logic [DataWidth-1:0] r_cfg_low, n_cfg_low;
    logic [DataWidth-1:0] r_cfg_high, n_cfg_high;
    logic [PinMax-1:0]    r_out_data, n_out_data;
    logic [PinMax-1:0]    r_lock_bits, n_lock_bits;
    logic                 r_key_locked, n_key_locked;
    t_key_step            r_key_step, n_key_step;

    // Result register.
    logic                 r_out_valid;
    logic [DataWidth-1:0] r_read_data, n_read_data;
    logic [PinMax-1:0]    r_pin_out;
    logic                 r_lock_active;

    logic                 accept;
    logic [PinMax-1:0]    writable;
    logic [DataWidth-1:0] mask_low;
    logic [DataWidth-1:0] mask_high;
    logic [PinMax-1:0]    wr_bits;
    logic                 wr_key;
    logic                 wr_same;
    t_key_step            restart_step;

    // A new item enters whenever the result register is empty or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Locked pins are protected only once the key sequence has completed.
    assign writable  = PinMask & ~(r_key_locked ? r_lock_bits : '0);
    assign mask_low  = nibble_mask(writable[7:0]);
    assign mask_high = nibble_mask(writable[15:8]);

    assign wr_bits      = i_write_data[PinMax-1:0] & PinMask;
    assign wr_key       = i_write_data[KeyBit];
    assign wr_same      = (wr_bits == r_lock_bits);
    assign restart_step = wr_key ? KEY_SET1 : KEY_IDLE;

    always_comb begin
        n_cfg_low    = r_cfg_low;
        n_cfg_high   = r_cfg_high;
        n_out_data   = r_out_data;
        n_lock_bits  = r_lock_bits;
        n_key_locked = r_key_locked;
        n_key_step   = r_key_step;
        n_read_data  = '0;

        if (i_op == OpWrite) begin
            unique case (i_reg_index)
                RegCfgLow: begin
                    n_cfg_low = (r_cfg_low & ~mask_low) | (i_write_data & mask_low);
                end
                RegCfgHigh: begin
                    n_cfg_high = (r_cfg_high & ~mask_high) | (i_write_data & mask_high);
                end
                RegOutData: begin
                    n_out_data = i_write_data[PinMax-1:0] & PinMask;
                end
                RegLock: begin
                    // Once locked, the lock register ignores writes entirely.
                    if (!r_key_locked) begin
                        n_lock_bits = wr_bits;
                        priority if (r_key_step == KEY_IDLE) begin
                            n_key_step = restart_step;
                        end else if (r_key_step == KEY_SET1 && !wr_key && wr_same) begin
                            n_key_step = KEY_CLR;
                        end else if (r_key_step == KEY_CLR && wr_key && wr_same) begin
                            n_key_step = KEY_SET2;
                        end else begin
                            n_key_step = restart_step;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else begin
            unique case (i_reg_index)
                RegCfgLow:  n_read_data = r_cfg_low;
                RegCfgHigh: n_read_data = r_cfg_high;
                RegInData:  n_read_data = DataWidth'(i_pin_in & PinMask);
                RegOutData: n_read_data = DataWidth'(r_out_data);
                RegLock: begin
                    // The read that completes the sequence still shows the key clear.
                    n_read_data = DataWidth'({r_key_locked, r_lock_bits});
                    if (!r_key_locked && r_key_step == KEY_SET2) begin
                        n_key_locked = 1'b1;
                        n_key_step   = KEY_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_low    <= CfgReset;
            r_cfg_high   <= CfgReset;
            r_out_data   <= '0;
            r_lock_bits  <= '0;
            r_key_locked <= 1'b0;
            r_key_step   <= KEY_IDLE;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_cfg_low    <= n_cfg_low;
                r_cfg_high   <= n_cfg_high;
                r_out_data   <= n_out_data;
                r_lock_bits  <= n_lock_bits;
                r_key_locked <= n_key_locked;
                r_key_step   <= n_key_step;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data   <= n_read_data;
            r_pin_out     <= n_out_data;
            r_lock_active <= n_key_locked;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_pin_out     = r_pin_out;
    assign o_lock_active = r_lock_active;

    // Once engaged, the lock holds until reset.
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_locked |=> r_key_locked)
        else $error("lock released without reset");

    // The lock register is frozen after the lock engages.
    a_lock_bits_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_locked |=> $stable(r_lock_bits))
        else $error("lock bits changed while locked");

    // A locked pin 0 keeps its configuration field.
    a_pin0_cfg_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_key_locked && r_lock_bits[0]) |=> $stable(r_cfg_low[3:0]))
        else $error("configuration of a locked pin changed");

    // The key sequence rests idle while the lock is engaged.
    a_step_idle_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_locked |-> (r_key_step == KEY_IDLE))
        else $error("key sequence active after lock");

    // No item is taken while a result is stalled in the result register.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("item accepted over a stalled result");

endmodule
